/* hdl/gls_pkg.sv */
// Package: shared constants, codes and helper functions for the glyph byte stream renderer.
`default_nettype none

package gls_pkg;

  // Glyph store geometry
  localparam int GLYPH_WORDS     = 8192;
  localparam int ADDR_W          = $clog2(GLYPH_WORDS);
  localparam int MAX_FONT_HEIGHT = 32;
  localparam int ROW_W           = $clog2(MAX_FONT_HEIGHT);
  localparam int HGT_W           = ROW_W + 1;
  localparam int WID_W           = 5;
  localparam int PROD_W          = HGT_W + 8;

  // Input commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  // Display controller command bytes
  localparam logic [7:0] LCD_COLSET = 8'h2A;
  localparam logic [7:0] LCD_ROWSET = 8'h2B;
  localparam logic [7:0] LCD_MEMWR  = 8'h2C;

  // Positions in the 11-byte header
  localparam logic [3:0] HDR_COLSET = 4'd0;
  localparam logic [3:0] HDR_ROWSET = 4'd5;
  localparam logic [3:0] HDR_MEMWR  = 4'd10;
  localparam logic [3:0] HDR_LEN    = 4'd11;

  // Configuration register indexes
  localparam logic [2:0] REG_OFFSET_X    = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [2:0] REG_FONT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FONT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FORE_COLOR  = 3'd4;
  localparam logic [2:0] REG_BACK_COLOR  = 3'd5;

  // Character code to glyph index (single-byte Cyrillic page)
  function automatic logic [7:0] glyph_index(input logic [7:0] code);
    logic [7:0] idx;
    if (code >= 8'd192) begin
      idx = code - 8'd96;
    end else if (code == 8'd168) begin
      idx = 8'd160;
    end else if (code == 8'd184) begin
      idx = 8'd161;
    end else if (code < 8'd32) begin
      idx = 8'd0;
    end else begin
      idx = code - 8'd32;
    end
    return idx;
  endfunction

  // Clamp width to 1..16
  function automatic logic [WID_W-1:0] eff_width(input logic [4:0] w);
    logic [WID_W-1:0] r;
    if (w == 5'd0) begin
      r = WID_W'(1);
    end else if (w > 5'd16) begin
      r = WID_W'(16);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // Clamp height to 1..MAX_FONT_HEIGHT
  function automatic logic [HGT_W-1:0] eff_height(input logic [5:0] h);
    logic [HGT_W-1:0] r;
    if (h == 6'd0) begin
      r = HGT_W'(1);
    end else if (7'(h) > 7'(MAX_FONT_HEIGHT)) begin
      r = HGT_W'(MAX_FONT_HEIGHT);
    end else begin
      r = HGT_W'(h);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/glyph_to_lcd_byte_stream.sv */
// Top level: renders one character from a glyph store into a serial LCD byte stream.
//
// Usage:
//   The input channel (in_valid / in_stall) carries commands. CMD_LOAD writes
//   in_glyph_word into the glyph store at in_glyph_addr. CMD_START latches the
//   cell position and character code and arms a new stream (restarts one in
//   progress). Each CMD_NEXT yields one byte on the result channel (out_valid /
//   out_stall): column-window command, four coordinate bytes, row-window
//   command, four bytes, memory-write command, then two RGB565 bytes per pixel
//   (high byte first), rows top to bottom, pixels left to right. A CMD_NEXT
//   with no armed stream, and the unused command code, give no transfer.
//   The input register takes each command, and its result is then loaded into
//   the output register. Throughput: one command per cycle while the receiver
//   does not stall; the glyph store read is issued as the command is taken,
//   so row starts do not slow the stream.
//   Receiver stall: the output register holds its transfer; the stage behind it
//   holds one command and in_stall rises only when both are occupied.
//   Reset: stream disarmed, registers at their defaults (offset_y 20, width 11, height
//   18, white on black). The glyph store is not cleared: load a glyph before rendering
//   it. Write configuration over the APB port only while idle; the block does not check.
`default_nettype none

module glyph_to_lcd_byte_stream
  import gls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  // Command channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [12:0]       in_glyph_addr,
  input  wire logic [15:0]       in_glyph_word,
  input  wire logic [9:0]        in_pos_x,
  input  wire logic [9:0]        in_pos_y,
  input  wire logic [7:0]        in_char_code,
  // Byte channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [7:0]        out_byte,
  output      logic              out_is_data,
  output      logic              out_select_end,
  output      logic              out_last
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  offset_x_r;
  logic [7:0]  offset_y_r;
  logic [4:0]  font_width_r;
  logic [5:0]  font_height_r;
  logic [15:0] fore_color_r;
  logic [15:0] back_color_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= 8'd0;
      offset_y_r    <= 8'd20;
      font_width_r  <= 5'd11;
      font_height_r <= 6'd18;
      fore_color_r  <= 16'hFFFF;
      back_color_r  <= 16'h0000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_OFFSET_X:    offset_x_r    <= pwdata[7:0];
        REG_OFFSET_Y:    offset_y_r    <= pwdata[7:0];
        REG_FONT_WIDTH:  font_width_r  <= pwdata[4:0];
        REG_FONT_HEIGHT: font_height_r <= pwdata[5:0];
        REG_FORE_COLOR:  fore_color_r  <= pwdata[15:0];
        REG_BACK_COLOR:  back_color_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_OFFSET_X:    prdata = 32'(offset_x_r);
      REG_OFFSET_Y:    prdata = 32'(offset_y_r);
      REG_FONT_WIDTH:  prdata = 32'(font_width_r);
      REG_FONT_HEIGHT: prdata = 32'(font_height_r);
      REG_FORE_COLOR:  prdata = 32'(fore_color_r);
      REG_BACK_COLOR:  prdata = 32'(back_color_r);
      default:         prdata = 32'd0;
    endcase
  end

  // Clamped geometry
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  assign w_eff = eff_width(font_width_r);
  assign h_eff = eff_height(font_height_r);

  // ---------------------------------------------------------------------
  // Handshake: input register (stage) and output register
  // ---------------------------------------------------------------------
  logic       s_valid_r;
  logic [1:0] s_cmd_r;
  logic [9:0] s_pos_x_r;
  logic [9:0] s_pos_y_r;
  logic [7:0] s_char_r;
  logic       s_go;
  logic       in_accept;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_is_data_r;
  logic       out_select_end_r;
  logic       out_last_r;

  // The stage advances unless the output register is full and stalled.
  assign s_go      = s_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s_valid_r && !s_go;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------
  logic              busy_r,       busy_nxt;
  logic [3:0]        hdr_idx_r,    hdr_idx_nxt;
  logic [ROW_W-1:0]  row_r,        row_nxt;
  logic [3:0]        col_r,        col_nxt;
  logic              low_r,        low_nxt;
  logic [9:0]        cell_x_r,     cell_x_nxt;
  logic [9:0]        cell_y_r,     cell_y_nxt;
  logic [ADDR_W-1:0] base_r,       base_nxt;
  logic [15:0]       row_bits_r,   row_bits_nxt;

  // Result of the stage
  logic       res;
  logic [7:0] res_byte;
  logic       res_is_data;
  logic       res_sel_end;
  logic       res_last;

  // Glyph store
  logic [15:0]       glyph_mem [GLYPH_WORDS];
  logic [15:0]       rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  // Header arithmetic
  logic [15:0] x1, x2, y1, y2, ca, cb;
  logic [1:0]  sub;
  logic [PROD_W-1:0] base_prod;

  // Pixel path
  logic [15:0] row_cur;
  logic        pix_bit;
  logic [15:0] color;
  logic        fin;
  logic [WID_W-1:0] col_inc;

  assign x1 = 16'(offset_x_r) + 16'(cell_x_r);
  assign x2 = x1 + 16'(w_eff) - 16'd1;
  assign y1 = 16'(offset_y_r) + 16'(cell_y_r);
  assign y2 = y1 + 16'(h_eff) - 16'd1;

  assign base_prod = PROD_W'(h_eff) * PROD_W'(glyph_index(s_char_r));

  // Fetch a fresh row word at the first byte of each row.
  assign row_cur = (col_r == 4'd0 && !low_r) ? rd_data_r : row_bits_r;
  assign pix_bit = row_cur[~col_r];
  assign color   = pix_bit ? fore_color_r : back_color_r;
  assign col_inc = WID_W'(col_r) + WID_W'(1);
  assign fin     = low_r && (col_inc >= w_eff) &&
                   (HGT_W'(row_r) + HGT_W'(1) >= h_eff);

  always_comb begin
    busy_nxt     = busy_r;
    hdr_idx_nxt  = hdr_idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    low_nxt      = low_r;
    cell_x_nxt   = cell_x_r;
    cell_y_nxt   = cell_y_r;
    base_nxt     = base_r;
    row_bits_nxt = row_bits_r;
    res          = 1'b0;
    res_byte     = 8'd0;
    res_is_data  = 1'b1;
    res_sel_end  = 1'b0;
    res_last     = 1'b0;
    ca           = x1;
    cb           = x2;
    sub          = 2'd0;

    if (s_go) begin
      case (s_cmd_r)
        CMD_START: begin
          cell_x_nxt  = s_pos_x_r;
          cell_y_nxt  = s_pos_y_r;
          base_nxt    = ADDR_W'(base_prod % GLYPH_WORDS);
          busy_nxt    = 1'b1;
          hdr_idx_nxt = 4'd0;
          row_nxt     = '0;
          col_nxt     = 4'd0;
          low_nxt     = 1'b0;
        end
        CMD_NEXT: begin
          if (busy_r) begin
            res = 1'b1;
            if (hdr_idx_r < HDR_LEN) begin
              // Header: window commands and coordinates
              if (hdr_idx_r < HDR_ROWSET) begin
                ca  = x1;
                cb  = x2;
                sub = 2'(hdr_idx_r - 4'd1);
              end else begin
                ca  = y1;
                cb  = y2;
                sub = 2'(hdr_idx_r - 4'd6);
              end
              case (sub)
                2'd0:    res_byte = ca[15:8];
                2'd1:    res_byte = ca[7:0];
                2'd2:    res_byte = cb[15:8];
                default: res_byte = cb[7:0];
              endcase
              if (hdr_idx_r == HDR_COLSET) begin
                res_byte    = LCD_COLSET;
                res_is_data = 1'b0;
              end else if (hdr_idx_r == HDR_ROWSET) begin
                res_byte    = LCD_ROWSET;
                res_is_data = 1'b0;
              end else if (hdr_idx_r == HDR_MEMWR) begin
                res_byte    = LCD_MEMWR;
                res_is_data = 1'b0;
                res_sel_end = 1'b1;
              end
              hdr_idx_nxt = hdr_idx_r + 4'd1;
            end else begin
              // Pixel data: high byte then low byte of the colour
              row_bits_nxt = row_cur;
              res_byte     = low_r ? color[7:0] : color[15:8];
              res_sel_end  = fin;
              res_last     = fin;
              if (!low_r) begin
                low_nxt = 1'b1;
              end else begin
                low_nxt = 1'b0;
                if (col_inc >= w_eff) begin
                  col_nxt = 4'd0;
                  row_nxt = row_r + ROW_W'(1);
                end else begin
                  col_nxt = col_inc[3:0];
                end
              end
              if (fin) begin
                busy_nxt    = 1'b0;
                hdr_idx_nxt = 4'd0;
                row_nxt     = '0;
                col_nxt     = 4'd0;
                low_nxt     = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Read for the command being taken, at the row it will need.
  assign rd_addr = base_nxt + ADDR_W'(row_nxt);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (in_cmd == CMD_LOAD) begin
        glyph_mem[ADDR_W'(in_glyph_addr)] <= in_glyph_word;
      end
      rd_data_r <= glyph_mem[rd_addr];
    end
  end

  // Stage and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r  <= 1'b0;
      busy_r     <= 1'b0;
      hdr_idx_r  <= 4'd0;
      row_r      <= '0;
      col_r      <= 4'd0;
      low_r      <= 1'b0;
      cell_x_r   <= 10'd0;
      cell_y_r   <= 10'd0;
      base_r     <= '0;
      row_bits_r <= 16'd0;
    end else begin
      if (in_accept) begin
        s_valid_r <= 1'b1;
      end else if (s_go) begin
        s_valid_r <= 1'b0;
      end
      busy_r     <= busy_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      low_r      <= low_nxt;
      cell_x_r   <= cell_x_nxt;
      cell_y_r   <= cell_y_nxt;
      base_r     <= base_nxt;
      row_bits_r <= row_bits_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_cmd_r   <= in_cmd;
      s_pos_x_r <= in_pos_x;
      s_pos_y_r <= in_pos_y;
      s_char_r  <= in_char_code;
    end
  end

  // Output register: load on a result, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_go && res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && res) begin
      out_byte_r       <= res_byte;
      out_is_data_r    <= res_is_data;
      out_select_end_r <= res_sel_end;
      out_last_r       <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_data    = out_is_data_r;
  assign out_select_end = out_select_end_r;
  assign out_last       = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_last_is_data_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_is_data && out_select_end))
    else $error("final pixel byte without data flag or select release");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_fin_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && res && res_last) |=> (!busy_r && hdr_idx_r == 4'd0))
    else $error("stream still armed after final pixel byte");

  a_cmd_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && res && !res_is_data) |-> (hdr_idx_r < HDR_LEN))
    else $error("command byte outside the header");

endmodule

`default_nettype wire
